@@ rtl/nnis_pkg.sv @@
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types, constants and helpers of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int PIXEL_BITS  = 16;
    localparam int DIM_BITS    = 9;
    localparam int COORD_BITS  = 8;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int FRAME_BITS  = ADDR_BITS + 1;
    localparam int REM2_BITS   = DIM_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(128);
    localparam logic [DIM_BITS-1:0] DIM_ONE   = DIM_BITS'(1);
    localparam logic [DIM_BITS-1:0] MAX_W_DIM = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] MAX_H_DIM = DIM_BITS'(MAX_HEIGHT);
    localparam logic [DIM_BITS-1:0] STEP_Q_RESET = DIM_BITS'(128 / 128);
    localparam logic [DIM_BITS-1:0] STEP_R_RESET = DIM_BITS'(128 % 128);
    localparam logic [FRAME_BITS-1:0] FRAME_RESET = FRAME_BITS'(128 * 128);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EMIT = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [PIXEL_BITS-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic [COORD_BITS-1:0] dest_x;
        logic [COORD_BITS-1:0] dest_y;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic advance;
    } axis_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // zero counts as one, anything above the maximum as the maximum
    function automatic logic [DIM_BITS-1:0] eff_dim(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS-1:0] maxv
    );
        logic [DIM_BITS-1:0] r;
        if (v == '0)
        begin
            r = DIM_ONE;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/nearest_neighbor_image_scaler.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Load requests fill the frame store in raster order, emit requests read
// back one nearest-neighbor sample of the destination image each.
// A load is written on accept; an emit's sample passes the store read register
// and rd_pend_reg, then out_valid_reg. One load per cycle while not held off;
// no request is taken while an emit's read is pending. A register write holds
// off requests while the serial dividers work out the per-pixel index steps.
// Reset: sizes return to 128, pointers and counters to zero; the frame store
// is not cleared and holds nothing defined until loaded.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_item_t                in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_item_t               out_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]     cfg_data
);

    logic [DIM_BITS-1:0]   src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [DIM_BITS-1:0]   sw, sh, dw, dh;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [ADDR_BITS-1:0]  load_ptr_reg, load_ptr_next;
    logic [FRAME_BITS-1:0] load_ptr_inc;
    logic                  start_reg;
    logic                  rd_pend_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic                  last_reg;
    logic                  busy;
    logic                  cfg_fire, in_fire, load_fire, emit_fire;

    logic [DIM_BITS-1:0]   qx, rx, qy, ry;
    div_status_t           div_x_st, div_y_st;
    axis_ctrl_t            x_ctrl, y_ctrl;
    logic [COORD_BITS-1:0] x_pos, x_idx, y_pos, y_idx;
    logic                  x_end, y_end;
    logic [FRAME_BITS-1:0] row_base;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [PIXEL_BITS-1:0] rd_data;

    assign sw = eff_dim(src_w_reg, MAX_W_DIM);
    assign sh = eff_dim(src_h_reg, MAX_H_DIM);
    assign dw = eff_dim(dst_w_reg, MAX_W_DIM);
    assign dh = eff_dim(dst_h_reg, MAX_H_DIM);

    assign busy      = start_reg | div_x_st.busy | div_y_st.busy
                     | div_x_st.done | div_y_st.done;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_ready  = !busy && !rd_pend_reg && !(out_valid_reg && !out_ready);
    assign in_fire   = in_valid & in_ready;
    assign load_fire = in_fire && (in_item.cmd == CMD_LOAD);
    assign emit_fire = in_fire && (in_item.cmd == CMD_EMIT);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= DIM_RESET;
            src_h_reg <= DIM_RESET;
            dst_w_reg <= DIM_RESET;
            dst_h_reg <= DIM_RESET;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= cfg_fire;
            if (cfg_fire)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SRC_WIDTH:  src_w_reg <= cfg_data;
                    CFG_SRC_HEIGHT: src_h_reg <= cfg_data;
                    CFG_DST_WIDTH:  dst_w_reg <= cfg_data;
                    CFG_DST_HEIGHT: dst_h_reg <= cfg_data;
                    default:        src_w_reg <= src_w_reg;
                endcase
            end
        end
    end

    // index steps: floor(s/d) and 2*(s mod d) per destination pixel
    nnis_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (sw),
        .divisor   (dw),
        .quotient  (qx),
        .remainder (rx),
        .status    (div_x_st)
    );

    nnis_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (sh),
        .divisor   (dh),
        .quotient  (qy),
        .remainder (ry),
        .status    (div_y_st)
    );

    assign x_ctrl.clear   = div_x_st.done;
    assign x_ctrl.advance = emit_fire;
    assign y_ctrl.clear   = div_y_st.done;
    assign y_ctrl.advance = emit_fire & x_end;

    nnis_axis u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (x_ctrl),
        .src      (sw),
        .dst      (dw),
        .step_q   (qx),
        .step_rem (rx),
        .pos      (x_pos),
        .idx      (x_idx),
        .at_end   (x_end)
    );

    nnis_axis u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (y_ctrl),
        .src      (sh),
        .dst      (dh),
        .step_q   (qy),
        .step_rem (ry),
        .pos      (y_pos),
        .idx      (y_idx),
        .at_end   (y_end)
    );

    // load pointer and frame size
    assign load_ptr_inc = {1'b0, load_ptr_reg} + 1'b1;

    always_comb
    begin
        load_ptr_next = load_ptr_reg;
        if (cfg_fire)
        begin
            load_ptr_next = '0;
        end
        else if (load_fire)
        begin
            load_ptr_next = (load_ptr_inc >= frame_reg) ? '0 : load_ptr_inc[ADDR_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            frame_reg    <= FRAME_RESET;
        end
        else
        begin
            load_ptr_reg <= load_ptr_next;
            if (start_reg)
            begin
                frame_reg <= FRAME_BITS'(sw * sh);
            end
        end
    end

    assign row_base = FRAME_BITS'(y_idx * sw);
    assign rd_addr  = ADDR_BITS'(row_base + {{(FRAME_BITS-COORD_BITS){1'b0}}, x_idx});

    nnis_frame_store #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (PIXEL_BITS)
    ) u_store (
        .clk   (clk),
        .we    (load_fire),
        .waddr (load_ptr_reg),
        .wdata (in_item.pixel_in),
        .re    (emit_fire),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // output register; the store read data holds until the next emit
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= emit_fire;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            dx_reg   <= x_pos;
            dy_reg   <= y_pos;
            last_reg <= x_end & y_end;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_item.pixel_out = rd_data;
    assign out_item.dest_x    = dx_reg;
    assign out_item.dest_y    = dy_reg;
    assign out_item.last      = last_reg;

endmodule

@@ rtl/nnis_frame_store.sv @@
// ----------------------------------------------------------------------------
// nnis_frame_store
// Simple dual-port frame buffer, one write and one registered read port.
// ----------------------------------------------------------------------------
module nnis_frame_store #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nnis_div.sv @@
// ----------------------------------------------------------------------------
// nnis_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnis_div
    import nnis_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIM_BITS-1:0] dividend,
    input  logic [DIM_BITS-1:0] divisor,
    output logic [DIM_BITS-1:0] quotient,
    output logic [DIM_BITS-1:0] remainder,
    output div_status_t         status
);

    localparam int CNT_BITS = $clog2(DIM_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIM_BITS - 1);

    logic [DIM_BITS-1:0] quo_reg, quo_next;
    logic [DIM_BITS-1:0] rem_reg, rem_next;
    logic [DIM_BITS-1:0] dsr_reg, dsr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIM_BITS:0]   shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIM_BITS-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = DIM_BITS'(shifted - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIM_BITS-1:0];
                quo_next = {quo_reg[DIM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= STEP_Q_RESET;
            rem_reg  <= STEP_R_RESET;
            dsr_reg  <= DIM_RESET;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/nnis_axis.sv @@
// ----------------------------------------------------------------------------
// nnis_axis
// Incremental nearest-index accumulator for one image axis.
// ----------------------------------------------------------------------------
module nnis_axis
    import nnis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  axis_ctrl_t            ctrl,
    input  logic [DIM_BITS-1:0]   src,
    input  logic [DIM_BITS-1:0]   dst,
    input  logic [DIM_BITS-1:0]   step_q,
    input  logic [DIM_BITS-1:0]   step_rem,
    output logic [COORD_BITS-1:0] pos,
    output logic [COORD_BITS-1:0] idx,
    output logic                  at_end
);

    // invariant: 2*pos*src + dst = q*2*dst + r, with r < 2*dst
    logic [COORD_BITS-1:0] pos_reg, pos_next;
    logic [DIM_BITS-1:0]   q_reg, q_next;
    logic [REM2_BITS-1:0]  r_reg, r_next;
    logic [REM2_BITS:0]    r_sum;
    logic [REM2_BITS:0]    two_dst;
    logic [DIM_BITS-1:0]   q_sum;
    logic [DIM_BITS-1:0]   src_last;

    assign two_dst  = {1'b0, dst, 1'b0};
    assign r_sum    = {1'b0, r_reg} + {1'b0, step_rem, 1'b0};
    assign q_sum    = q_reg + step_q;
    assign src_last = src - DIM_ONE;
    assign at_end   = ({1'b0, pos_reg} == DIM_BITS'(dst - DIM_ONE));

    always_comb
    begin
        pos_next = pos_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        if (ctrl.clear || (ctrl.advance && at_end))
        begin
            pos_next = '0;
            q_next   = '0;
            r_next   = {1'b0, dst};
        end
        else if (ctrl.advance)
        begin
            pos_next = pos_reg + 1'b1;
            if (r_sum >= two_dst)
            begin
                r_next = REM2_BITS'(r_sum - two_dst);
                q_next = q_sum + 1'b1;
            end
            else
            begin
                r_next = r_sum[REM2_BITS-1:0];
                q_next = q_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            q_reg   <= '0;
            r_reg   <= {1'b0, DIM_RESET};
        end
        else
        begin
            pos_reg <= pos_next;
            q_reg   <= q_next;
            r_reg   <= r_next;
        end
    end

    assign pos = pos_reg;
    assign idx = (q_reg > src_last) ? src_last[COORD_BITS-1:0] : q_reg[COORD_BITS-1:0];

endmodule
